### rtl/core/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types and codes for the linked list engine: request and result
// items and operation codes.
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int POS_W = 11;
	localparam int LEN_W = 10;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_FIND   = 2'd2,
		FN_READ   = 2'd3
	} func_e_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic                    ok;
		logic [POS_W-1:0]        found_position;
		logic signed [VAL_W-1:0] read_data;
		logic [LEN_W-1:0]        list_length;
	} rsp_t;

endpackage

### rtl/core/sll_ram.sv
// ----------------------------------------------------------------------------
// sll_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (read-during-write gives old data).
// ----------------------------------------------------------------------------
module sll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/static_linked_list_engine.sv
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Array-backed singly linked list of signed words with a free-slot chain.
// ----------------------------------------------------------------------------
// Usage: after reset the block is busy while it writes the free chain into
// the link memory (slots 1 .. DEPTH-2 chained, end marked 0).
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and it cannot be held off.
// The worst case is set by the chain walk, which follows one link per cycle
// through the read port of the link memory. A new item may be started in the
// same cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sll_pkg::req_t request,
	output logic          done,
	output sll_pkg::rsp_t result
);

	import sll_pkg::*;

	localparam int AW = $clog2(DEPTH);
	// compare width: holds a position and the length plus one
	localparam int CW = (AW + 1 > POS_W) ? AW + 1 : POS_W;

	typedef enum logic [10:0] {
		ST_INIT  = 11'b000_0000_0001,  // free chain build after reset
		ST_IDLE  = 11'b000_0000_0010,
		ST_ALLOC = 11'b000_0000_0100,  // pop free slot
		ST_WALK  = 11'b000_0000_1000,  // follow links to a position
		ST_ILINK = 11'b000_0001_0000,  // new.link = prev.link
		ST_IPREV = 11'b000_0010_0000,  // prev.link = new
		ST_DVICT = 11'b000_0100_0000,  // victim = prev.link
		ST_DNEXT = 11'b000_1000_0000,  // unlink victim
		ST_DFREE = 11'b001_0000_0000,  // push victim on free chain
		ST_RDATA = 11'b010_0000_0000,
		ST_FIND  = 11'b100_0000_0000   // scan, one node per cycle
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   count_q;
	logic [AW-1:0]   free_head_q;
	logic [AW-1:0]   list_head_q;
	func_e_t         op_q;
	logic [VAL_W-1:0] val_q;
	logic            pos1_q;
	logic [AW-1:0]   steps_q;
	logic [AW-1:0]   cur_q;
	logic            pend_q;
	logic [AW-1:0]   new_q;
	logic [AW-1:0]   victim_q;
	logic [AW-1:0]   cnt_q;
	logic            done_q;
	rsp_t            res_q;

	// memory ports
	logic            l_we;
	logic [AW-1:0]   l_waddr;
	logic [AW-1:0]   l_wdata;
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   link_rd;
	logic            v_we;
	logic [VAL_W-1:0] value_rd;

	logic            accept;
	logic [CW-1:0]   pos_c;
	logic [CW-1:0]   cnt_c;
	logic            ins_ok;
	logic            pos_ok;
	logic [AW-1:0]   eff;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign accept = start && !busy;

	assign pos_c  = CW'(request.position);
	assign cnt_c  = CW'(count_q);
	assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + CW'(1)) && (free_head_q != '0);
	assign pos_ok = (pos_c != '0) && (pos_c <= cnt_c);

	// current node during a walk or scan: straight off the read port while a link is pending, else cur_q
	assign eff = pend_q ? link_rd : cur_q;

	function automatic rsp_t mk_rsp(input logic ok, input logic [AW-1:0] fpos,
			input logic [VAL_W-1:0] rdata, input logic [AW-1:0] len);
		rsp_t r;
		r.ok             = ok;
		r.found_position = POS_W'(fpos);
		r.read_data      = rdata;
		r.list_length    = LEN_W'(len);
		return r;
	endfunction

	always_comb begin
		l_we    = 1'b0;
		l_waddr = cur_q;
		l_wdata = link_rd;
		raddr   = cur_q;
		v_we    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				l_we    = 1'b1;
				l_waddr = clr_q;
				l_wdata = ((clr_q != '0) && (clr_q < AW'(DEPTH - 2))) ? clr_q + AW'(1) : '0;
			end
			ST_IDLE: begin
				raddr = (request.func == FN_INSERT) ? free_head_q : list_head_q;
				v_we  = accept && (request.func == FN_INSERT) && ins_ok;
			end
			ST_ALLOC: begin
				if (pos1_q) begin
					l_we    = 1'b1;
					l_waddr = new_q;
					l_wdata = list_head_q;
				end
			end
			ST_WALK, ST_FIND: begin
				raddr = eff;
			end
			ST_ILINK: begin
				l_we    = 1'b1;
				l_waddr = new_q;
				l_wdata = link_rd;
			end
			ST_IPREV: begin
				l_we    = 1'b1;
				l_waddr = cur_q;
				l_wdata = new_q;
			end
			ST_DVICT: begin
				raddr = link_rd;
			end
			ST_DNEXT: begin
				l_we    = !pos1_q;
				l_waddr = cur_q;
				l_wdata = link_rd;
			end
			ST_DFREE: begin
				l_we    = 1'b1;
				l_waddr = victim_q;
				l_wdata = free_head_q;
			end
			ST_RDATA: begin
			end
			default: begin
			end
		endcase
	end

	sll_ram #(
		.WIDTH (AW),
		.DEPTH (DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (raddr),
		.rdata (link_rd)
	);

	sll_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (free_head_q),
		.wdata (request.value),
		.raddr (raddr),
		.rdata (value_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			count_q     <= '0;
			free_head_q <= AW'(1);
			list_head_q <= '0;
			op_q        <= FN_INSERT;
			val_q       <= '0;
			pos1_q      <= 1'b0;
			steps_q     <= '0;
			cur_q       <= '0;
			pend_q      <= 1'b0;
			new_q       <= '0;
			victim_q    <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			res_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q   <= func_e_t'(request.func);
						val_q  <= request.value;
						pos1_q <= (pos_c == CW'(1));
						cur_q  <= list_head_q;
						pend_q <= 1'b0;
						cnt_q  <= '0;
						unique case (request.func)
							FN_INSERT: begin
								steps_q <= AW'(pos_c - CW'(2));
								if (ins_ok) begin
									new_q   <= free_head_q;
									state_q <= ST_ALLOC;
								end else begin
									res_q  <= mk_rsp(1'b0, '0, '0, count_q);
									done_q <= 1'b1;
								end
							end
							FN_DELETE: begin
								steps_q  <= AW'(pos_c - CW'(2));
								victim_q <= list_head_q;
								if (!pos_ok) begin
									res_q  <= mk_rsp(1'b0, '0, '0, count_q);
									done_q <= 1'b1;
								end else if (pos_c == CW'(1)) begin
									state_q <= ST_DNEXT;
								end else begin
									state_q <= ST_WALK;
								end
							end
							FN_FIND: begin
								state_q <= ST_FIND;
							end
							FN_READ: begin
								steps_q <= AW'(pos_c - CW'(1));
								if (pos_ok) begin
									state_q <= ST_WALK;
								end else begin
									res_q  <= mk_rsp(1'b0, '0, '0, count_q);
									done_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ALLOC: begin
					free_head_q <= link_rd;
					if (pos1_q) begin
						list_head_q <= new_q;
						count_q     <= count_q + AW'(1);
						res_q       <= mk_rsp(1'b1, '0, '0, count_q + AW'(1));
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					cur_q <= eff;
					if (steps_q == '0) begin
						pend_q <= 1'b0;
						unique case (op_q)
							FN_INSERT: state_q <= ST_ILINK;
							FN_DELETE: state_q <= ST_DVICT;
							default:   state_q <= ST_RDATA;
						endcase
					end else begin
						pend_q  <= 1'b1;
						steps_q <= steps_q - AW'(1);
					end
				end
				ST_ILINK: begin
					state_q <= ST_IPREV;
				end
				ST_IPREV: begin
					count_q <= count_q + AW'(1);
					res_q   <= mk_rsp(1'b1, '0, '0, count_q + AW'(1));
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DVICT: begin
					victim_q <= link_rd;
					state_q  <= ST_DNEXT;
				end
				ST_DNEXT: begin
					if (pos1_q) begin
						list_head_q <= link_rd;
					end
					state_q <= ST_DFREE;
				end
				ST_DFREE: begin
					free_head_q <= victim_q;
					count_q     <= count_q - AW'(1);
					res_q       <= mk_rsp(1'b1, '0, '0, count_q - AW'(1));
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_RDATA: begin
					res_q   <= mk_rsp(1'b1, '0, value_rd, count_q);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FIND: begin
					if (pend_q && (value_rd == val_q)) begin
						res_q   <= mk_rsp(1'b1, cnt_q, '0, count_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (eff == '0) begin
						res_q   <= mk_rsp(1'b0, '0, '0, count_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						cur_q  <= eff;
						pend_q <= 1'b1;
						cnt_q  <= cnt_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(DEPTH - 2))
		else $error("element count above capacity");

	a_full_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((free_head_q == '0) == (count_q == AW'(DEPTH - 2))))
		else $error("free chain empty does not match a full store");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((list_head_q == '0) == (count_q == '0)))
		else $error("list head does not match list length");

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(start && !busy) || !$past(state_q == ST_IDLE))
		else $error("result without a pending item");
`endif

endmodule

### test/sll_list_checker.sv
// ----------------------------------------------------------------------------
// sll_list_checker
// Watches the request and result channels of the linked list engine. It keeps
// its own copy of the list, the free chain and the length, works out the
// result of each accepted item, and compares results in order.
// ----------------------------------------------------------------------------
module sll_list_checker #(
	parameter int DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  sll_pkg::req_t request,
	input  logic          done,
	input  sll_pkg::rsp_t result,
	output int            mismatch_count,
	output int            results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import sll_pkg::*;

	localparam int MSG_CAP = 50;

	int unsigned             next_slot [DEPTH];
	logic signed [VAL_W-1:0] slot_value [DEPTH];
	int unsigned             elem_count;
	int unsigned             free_head;
	int unsigned             list_head;

	rsp_t pending_results [$];
	int   mismatches = 0;
	int   owed = 0;

	assign mismatch_count = mismatches;
	assign results_owed   = owed;

	task automatic clear_list();
		for (int i = 0; i < DEPTH; i++) begin
			next_slot[i]  = 0;
			slot_value[i] = '0;
		end
		// free chain 1 -> 2 -> ... -> DEPTH-2, 0 ends it
		for (int i = 1; i + 2 < DEPTH; i++)
			next_slot[i] = i + 1;
		elem_count = 0;
		free_head  = 1;
		list_head  = 0;
	endtask

	function automatic int unsigned slot_at(int unsigned pos);
		int unsigned s;
		s = list_head;
		for (int unsigned n = 1; n < pos && n < DEPTH; n++)
			s = next_slot[s];
		return s;
	endfunction

	// Applies one item to the shadow list and returns the result it gives.
	function automatic rsp_t list_op_outcome(req_t r);
		rsp_t        o;
		int unsigned pos;
		int unsigned slot;
		int unsigned prev;
		int unsigned cnt;
		o   = '0;
		pos = r.position;
		case (func_e_t'(r.func))
			FN_INSERT: begin
				if (pos >= 1 && pos <= elem_count + 1 && free_head != 0
						&& free_head < DEPTH) begin
					slot = free_head;
					free_head = next_slot[slot];
					slot_value[slot] = r.value;
					if (pos == 1) begin
						next_slot[slot] = list_head;
						list_head = slot;
					end else begin
						prev = slot_at(pos - 1);
						next_slot[slot] = next_slot[prev];
						next_slot[prev] = slot;
					end
					elem_count++;
					o.ok = 1'b1;
				end
			end
			FN_DELETE: begin
				if (pos >= 1 && pos <= elem_count) begin
					if (pos == 1) begin
						slot = list_head;
						list_head = next_slot[slot];
					end else begin
						prev = slot_at(pos - 1);
						slot = next_slot[prev];
						next_slot[prev] = next_slot[slot];
					end
					next_slot[slot] = free_head;
					free_head = slot;
					elem_count--;
					o.ok = 1'b1;
				end
			end
			FN_FIND: begin
				slot = list_head;
				cnt  = 1;
				while (slot != 0 && cnt <= elem_count && !o.ok) begin
					if (slot_value[slot] == r.value) begin
						o.ok = 1'b1;
						o.found_position = cnt[POS_W-1:0];
					end else begin
						slot = next_slot[slot];
						cnt++;
					end
				end
			end
			FN_READ: begin
				if (pos >= 1 && pos <= elem_count) begin
					o.read_data = slot_value[slot_at(pos)];
					o.ok = 1'b1;
				end
			end
		endcase
		o.list_length = elem_count[LEN_W-1:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MSG_CAP)
			$display("%0t: %s", $realtime, what);
		mismatches++;
	endtask

	initial clear_list();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			clear_list();
			pending_results.delete();
			owed = 0;
		end else begin
			// retire first: an item taken this edge has its result later
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with no item outstanding, length %0d",
						result.list_length));
				end else begin
					want = pending_results.pop_front();
					if (result.ok !== want.ok)
						report_mismatch($sformatf("ok %b, expected %b",
							result.ok, want.ok));
					if (result.found_position !== want.found_position)
						report_mismatch($sformatf("found_position %0d, expected %0d",
							result.found_position, want.found_position));
					if (result.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %0d, expected %0d",
							result.read_data, want.read_data));
					if (result.list_length !== want.list_length)
						report_mismatch($sformatf("list_length %0d, expected %0d",
							result.list_length, want.list_length));
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				pending_results.push_back(list_op_outcome(request));
			owed = pending_results.size();
		end
	end

endmodule

### test/static_linked_list_engine_tb.sv
// ----------------------------------------------------------------------------
// static_linked_list_engine_tb
// Drives insert, delete, find and read items into the linked list engine and
// lets the checker compare every result against its own shadow list. A short
// directed run covers the empty list, range refusals, duplicates and all four
// operations; random items then work a list of moderate length under several
// idle patterns.
// ----------------------------------------------------------------------------
module static_linked_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sll_pkg::*;

	localparam int DEPTH = 1024;
	localparam int RANDOM_ITEMS = 556;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;

	int          mismatches;
	int          owed;
	int unsigned len_hint = 0;     // length reported by the latest result
	int unsigned idle_pct = 0;     // chance per cycle that the sender holds off

	logic signed [VAL_W-1:0] value_pool [8];

	static_linked_list_engine #(.DEPTH(DEPTH)) dut (
		.clk, .arst_n, .start, .busy, .request, .done, .result
	);

	sll_list_checker #(.DEPTH(DEPTH)) list_checker (
		.clk, .arst_n, .start, .busy, .request, .done, .result,
		.mismatch_count(mismatches),
		.results_owed(owed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Length feedback for choosing positions. It can lag by one item, which
	// only shifts the mix of in-range and refused positions a little.
	always @(posedge clk)
		if (done === 1'b1)
			len_hint <= result.list_length;

	// Called at a falling edge; returns at the falling edge after the item
	// is taken, with start still high so back-to-back items stay seamless.
	task automatic issue(input func_e_t fn, input logic signed [VAL_W-1:0] v,
			input int unsigned p);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		request <= '{func: fn, value: v, position: p[POS_W-1:0]};
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		// pooled values make finds hit and duplicates common
		if ($urandom_range(0, 1))
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	task automatic random_item();
		int unsigned len;
		int unsigned roll;
		int unsigned pos;
		int unsigned w_ins;
		int unsigned w_del;
		func_e_t     fn;
		len = len_hint;
		// steer the length: grow a short list, shrink a long one
		if (len < 4) begin
			w_ins = 60;
			w_del = 10;
		end else if (len > 40) begin
			w_ins = 15;
			w_del = 45;
		end else begin
			w_ins = 35;
			w_del = 25;
		end
		roll = $urandom_range(0, 99);
		if (roll < w_ins)
			fn = FN_INSERT;
		else if (roll < w_ins + w_del)
			fn = FN_DELETE;
		else if (roll < w_ins + w_del + 20)
			fn = FN_FIND;
		else
			fn = FN_READ;
		roll = $urandom_range(0, 99);
		if (roll < 85)
			pos = $urandom_range(1, fn == FN_INSERT ? len + 1 : (len == 0 ? 1 : len));
		else if (roll < 90)
			pos = 0;
		else if (roll < 95)
			pos = len + 1 + $urandom_range(0, 1);
		else
			pos = $urandom_range(0, 2047);
		issue(fn, pick_value(), pos);
	endtask

	initial begin
		int unsigned phase_idle [4];

		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h7FFF_FFFF;
		value_pool[3] = 32'h8000_0000;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();
		// the receiver cannot stall here, so the phases vary only the sender's idling
		phase_idle = '{0, 71, 0, 18};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The engine is busy clearing after reset; the first
		// handshake simply waits that out.
		issue(FN_READ,   32'h0, 1);              // empty list: read refused
		issue(FN_DELETE, 32'h0, 1);              // empty list: delete refused
		issue(FN_FIND,   32'h0, 0);              // empty list: nothing found
		issue(FN_INSERT, 32'h1, 0);              // position zero refused
		issue(FN_INSERT, 32'h1, 2);              // beyond length+1 refused
		issue(FN_INSERT, 32'h7FFF_FFFF, 1);      // first element
		issue(FN_INSERT, 32'h8000_0000, 2);      // append
		issue(FN_INSERT, 32'h0, 1);              // new head
		issue(FN_INSERT, 32'hFFFF_FFFF, 3);      // middle
		issue(FN_INSERT, 32'h7FFF_FFFF, 5);      // duplicate at the tail
		issue(FN_INSERT, 32'h1, 7);              // beyond length+1 refused
		issue(FN_FIND,   32'h7FFF_FFFF, 0);      // first of two matches
		issue(FN_FIND,   32'h8000_0000, 0);
		issue(FN_FIND,   32'h0000_3039, 0);      // absent value
		issue(FN_READ,   32'h0, 5);              // last element
		issue(FN_READ,   32'h0, 6);              // one past the end
		issue(FN_READ,   32'h0, 0);
		issue(FN_DELETE, 32'h0, 3);              // middle
		issue(FN_DELETE, 32'h0, 4);              // tail
		issue(FN_DELETE, 32'h0, 1);              // head
		issue(FN_INSERT, 32'h1, 2047);           // all position bits set
		issue(FN_READ,   32'h0, 2047);
		issue(FN_DELETE, 32'h0, 1024);           // position DEPTH, refused
		issue(FN_FIND,   32'hFFFF_FFFF, 0);      // deleted value now absent
		issue(FN_INSERT, 32'h5555_AAAA, 1);      // freed slot reused

		// Random part, split into idle phases.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			for (int i = 0; i < RANDOM_ITEMS / 4; i++)
				random_item();
		end

		// Wind down: bounded wait for the last results, then room for strays.
		start <= 1'b0;
		for (int i = 0; i < 8 * DEPTH && owed != 0; i++)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		if (mismatches == 0 && owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hang guard: far beyond every item taking a full chain walk plus gaps.
	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### static_linked_list_engine.f
rtl/core/sll_pkg.sv
rtl/core/sll_ram.sv
rtl/core/static_linked_list_engine.sv
test/sll_list_checker.sv
test/static_linked_list_engine_tb.sv
